>>> hw/rtl/pfp_pkg.sv
// ---------------------------------------------------------------------------
// Particulate frame parser package
// Shared types and constants of the sensor frame parser.
// ---------------------------------------------------------------------------
package pfp_pkg;

   localparam logic [7:0]  START_FIRST  = 8'h42;
   localparam logic [7:0]  START_SECOND = 8'h4D;
   localparam int          FRAME_BYTES  = 32;
   localparam int          POS_W        = $clog2(FRAME_BYTES);

   localparam logic [POS_W-1:0] POS_FIRST_DATA = POS_W'(2);
   localparam logic [POS_W-1:0] POS_PM1_HI     = POS_W'(4);
   localparam logic [POS_W-1:0] POS_PM1_LO     = POS_W'(5);
   localparam logic [POS_W-1:0] POS_PM25_HI    = POS_W'(6);
   localparam logic [POS_W-1:0] POS_PM25_LO    = POS_W'(7);
   localparam logic [POS_W-1:0] POS_PM10_HI    = POS_W'(8);
   localparam logic [POS_W-1:0] POS_PM10_LO    = POS_W'(9);
   localparam logic [POS_W-1:0] POS_CHECK_HI   = POS_W'(FRAME_BYTES - 2);
   localparam logic [POS_W-1:0] POS_LAST       = POS_W'(FRAME_BYTES - 1);

   localparam logic [15:0] START_SUM   = 16'({8'h00, START_FIRST} + {8'h00, START_SECOND});
   localparam logic [15:0] LIMIT_RESET = 16'd1000;
   localparam logic        CHECK_RESET = 1'b1;

   typedef enum logic [0:0] {
      REG_VALUE_LIMIT  = 1'b0,
      REG_CHECK_ENABLE = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CHECKSUM = 2'd1,
      STATUS_SANITY   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'b001,
      PH_FIRST   = 3'b010,
      PH_COLLECT = 3'b100
   } phase_type;

   typedef struct packed {
      logic [15:0] value_limit;
      logic        check_enable;
   } cfg_type;

endpackage

>>> hw/rtl/particulate_frame_parser.sv
// ---------------------------------------------------------------------------
// Particulate frame parser
// Hunts for the start pair, collects a 32-byte frame, checks it and emits
// the three readings with a status.
// Result: registered, valid in the cycle after the last frame byte is taken.
// Throughput: one byte per cycle unless stalled; per-byte add and compare set it.
// Input stalls only on the last frame byte while a result is still held.
// Reset: synchronous; hunting state, limit 1000, checks enabled, no result.
// ---------------------------------------------------------------------------
module particulate_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_pm1_value,
   output logic [15:0] rsp_pm25_value,
   output logic [15:0] rsp_pm10_value,
   output logic [1:0]  rsp_frame_status,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int POS_W = pfp_pkg::POS_W;

   pfp_pkg::cfg_type    cfg_ff, cfg_in;
   pfp_pkg::phase_type  phase_ff, phase_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [15:0]         sum_ff, sum_in;
   logic [15:0]         pm1_ff, pm1_in;
   logic [15:0]         pm25_ff, pm25_in;
   logic [15:0]         pm10_ff, pm10_in;
   logic [7:0]          chk_hi_ff, chk_hi_in;

   logic                out_valid_ff, out_valid_in;
   logic [15:0]         out_pm1_ff, out_pm25_ff, out_pm10_ff;
   logic [1:0]          out_status_ff;

   logic                req_fire, rsp_fire, at_last, emit;
   pfp_pkg::status_type status;

   assign at_last   = (phase_ff == pfp_pkg::PH_COLLECT) && (pos_ff == pfp_pkg::POS_LAST);
   assign req_stall = out_valid_ff && rsp_stall && at_last;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = out_valid_ff && !rsp_stall;
   assign emit      = req_fire && at_last;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (pfp_pkg::reg_index_type'(csr_index))
            pfp_pkg::REG_VALUE_LIMIT:  cfg_in.value_limit  = csr_data;
            pfp_pkg::REG_CHECK_ENABLE: cfg_in.check_enable = csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      pm1_in    = pm1_ff;
      pm25_in   = pm25_ff;
      pm10_in   = pm10_ff;
      chk_hi_in = chk_hi_ff;
      if (req_fire) begin
         case (phase_ff)
            pfp_pkg::PH_FIRST: begin
               if (req_byte_value == pfp_pkg::START_SECOND) begin
                  phase_in = pfp_pkg::PH_COLLECT;
                  pos_in   = pfp_pkg::POS_FIRST_DATA;
                  sum_in   = pfp_pkg::START_SUM;
               end else if (req_byte_value != pfp_pkg::START_FIRST) begin
                  phase_in = pfp_pkg::PH_HUNT;
               end
            end
            pfp_pkg::PH_COLLECT: begin
               if (pos_ff < pfp_pkg::POS_CHECK_HI) begin
                  sum_in = 16'(sum_ff + {8'h00, req_byte_value});
               end
               case (pos_ff)
                  pfp_pkg::POS_PM1_HI:   pm1_in[15:8]  = req_byte_value;
                  pfp_pkg::POS_PM1_LO:   pm1_in[7:0]   = req_byte_value;
                  pfp_pkg::POS_PM25_HI:  pm25_in[15:8] = req_byte_value;
                  pfp_pkg::POS_PM25_LO:  pm25_in[7:0]  = req_byte_value;
                  pfp_pkg::POS_PM10_HI:  pm10_in[15:8] = req_byte_value;
                  pfp_pkg::POS_PM10_LO:  pm10_in[7:0]  = req_byte_value;
                  pfp_pkg::POS_CHECK_HI: chk_hi_in     = req_byte_value;
                  default: ;
               endcase
               if (pos_ff == pfp_pkg::POS_LAST) begin
                  phase_in = pfp_pkg::PH_HUNT;
                  pos_in   = '0;
               end else begin
                  pos_in = POS_W'(pos_ff + 1'b1);
               end
            end
            default: begin
               phase_in = (req_byte_value == pfp_pkg::START_FIRST) ?
                          pfp_pkg::PH_FIRST : pfp_pkg::PH_HUNT;
            end
         endcase
      end
   end

   pfp_status u_status (
      .cfg         (cfg_ff),
      .pm1         (pm1_ff),
      .pm25        (pm25_ff),
      .pm10        (pm10_ff),
      .check_word  ({chk_hi_ff, req_byte_value}),
      .running_sum (sum_ff),
      .status      (status)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_fire) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{value_limit: pfp_pkg::LIMIT_RESET,
                           check_enable: pfp_pkg::CHECK_RESET};
         phase_ff     <= pfp_pkg::PH_HUNT;
         pos_ff       <= '0;
         sum_ff       <= '0;
         pm1_ff       <= '0;
         pm25_ff      <= '0;
         pm10_ff      <= '0;
         chk_hi_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         pm1_ff       <= pm1_in;
         pm25_ff      <= pm25_in;
         pm10_ff      <= pm10_in;
         chk_hi_ff    <= chk_hi_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (emit) begin
         out_pm1_ff    <= pm1_ff;
         out_pm25_ff   <= pm25_ff;
         out_pm10_ff   <= pm10_ff;
         out_status_ff <= status;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pm1_value    = out_pm1_ff;
   assign rsp_pm25_value   = out_pm25_ff;
   assign rsp_pm10_value   = out_pm10_ff;
   assign rsp_frame_status = out_status_ff;

   a_stall_needs_held_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (out_valid_ff && at_last))
      else $error("input stalled without a held result on the last byte");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid)
      else $error("result not presented after last frame byte");

   a_emit_resumes_hunt: assert property (@(posedge clock) disable iff (reset)
      emit |=> (phase_ff == pfp_pkg::PH_HUNT && pos_ff == '0))
      else $error("parser did not resume hunting after a frame");

   a_collect_position: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == pfp_pkg::PH_COLLECT) |-> (pos_ff >= pfp_pkg::POS_FIRST_DATA))
      else $error("frame position below first data byte while collecting");

endmodule

>>> hw/rtl/pfp_status.sv
// ---------------------------------------------------------------------------
// Particulate frame parser status evaluation
// Compares checksum with the running sum; range and order checks apply when enabled.
// ---------------------------------------------------------------------------
module pfp_status (
   input  pfp_pkg::cfg_type    cfg,
   input  logic [15:0]         pm1,
   input  logic [15:0]         pm25,
   input  logic [15:0]         pm10,
   input  logic [15:0]         check_word,
   input  logic [15:0]         running_sum,
   output pfp_pkg::status_type status
);

   logic sanity_fail;

   assign sanity_fail = (pm1 > cfg.value_limit) || (pm25 > cfg.value_limit) ||
                        (pm10 > cfg.value_limit) || (pm25 < pm1) || (pm10 < pm25);

   always_comb begin
      if (check_word != running_sum) begin
         status = pfp_pkg::STATUS_CHECKSUM;
      end else if (cfg.check_enable && sanity_fail) begin
         status = pfp_pkg::STATUS_SANITY;
      end else begin
         status = pfp_pkg::STATUS_OK;
      end
   end

endmodule
